// ===== rtl/mm3_pkg.sv =====
// Shared constants, types and helper functions for the MurmurHash3 x64 128-bit block.
`timescale 1ns / 1ps

package mm3_pkg;

    typedef logic [63:0] t_word;

    localparam t_word MUL_C1  = 64'h87C3_7B91_1142_53D5;
    localparam t_word MUL_C2  = 64'h4CF5_AD43_2745_937F;
    localparam t_word FMIX_M1 = 64'hFF51_AFD7_ED55_8CCD;
    localparam t_word FMIX_M2 = 64'hC4CE_B9FE_1A85_EC53;
    localparam t_word ADD_H1  = 64'h0000_0000_52DC_E729;
    localparam t_word ADD_H2  = 64'h0000_0000_3849_5AB5;

    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned HALF_BYTES  = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified block as handed from the front end to the mixing core.
    typedef struct packed {
        t_word       k1;
        t_word       k2;
        logic        full;
        logic        last;
        logic        start;
        logic [31:0] len;
    } t_job;

    function automatic t_word rotl64(t_word x, int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_word fmix_shift(t_word x);
        return x ^ (x >> 33);
    endfunction

    // Keep the lowest n bytes of a word, n from 0 to 8.
    function automatic t_word byte_mask(logic [3:0] n);
        t_word m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/mm3_in_if.sv =====
// Request channel: one 16-byte message block with its byte count and last flag.
`timescale 1ns / 1ps

interface mm3_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  byte_count;
    logic        last;

    modport source (output valid, block_low, block_high, byte_count, last, input ready);
    modport sink   (input valid, block_low, block_high, byte_count, last, output ready);
endinterface

// ===== rtl/mm3_out_if.sv =====
// Result channel: 128-bit digest and length overflow flag.
`timescale 1ns / 1ps

interface mm3_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_low;
    logic [63:0] hash_high;
    logic        too_long;

    modport source (output valid, hash_low, hash_high, too_long, input ready);
    modport sink   (input valid, hash_low, hash_high, too_long, output ready);
endinterface

// ===== rtl/murmur3_x64_128_hash_top.sv =====
// Top level of the MurmurHash3 x64 128-bit streaming hash block.
`timescale 1ns / 1ps

// Streams a message as 16-byte little-endian blocks and returns the 128-bit
// MurmurHash3 x64 digest once per message, on the request marked last. The
// seed is written through i_seed_we / i_seed_wdata while no message is in
// flight and applies to messages that start afterwards. Requests pass into a
// two-entry queue, so the request side keeps flowing while the core works
// until the queue is full. The core does all 64-bit products on one 32x32
// multiplier, three partial products per 64-bit product. A final block also
// runs the length fold and finalizer, and the core may wait on the result
// channel. too_long flags messages above 2^31-1 bytes; the byte total
// saturates at 2^32-1.
module murmur3_x64_128_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_wdata,
    mm3_in_if.sink      i_req,
    mm3_out_if.source   o_rsp
);
    import mm3_pkg::*;

    t_job front_job;
    t_job queue_job;
    logic push;
    logic queue_full;
    logic queue_valid;
    logic pop;

    mm3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (queue_full),
        .o_push  (push),
        .o_job   (front_job)
    );

    mm3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_job   (queue_job)
    );

    mm3_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_wdata (i_seed_wdata),
        .i_job_valid  (queue_valid),
        .i_job        (queue_job),
        .o_job_pop    (pop),
        .o_rsp        (o_rsp)
    );

endmodule

// ===== rtl/mm3_mul.sv =====
// Iterative 64x64 multiplier (low 64 bits) built on one shared 32x32 multiplier.
`timescale 1ns / 1ps

module mm3_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  mm3_pkg::t_word i_a,
    input  mm3_pkg::t_word i_b,
    output logic           o_done,
    output mm3_pkg::t_word o_p
);
    import mm3_pkg::*;

    localparam logic [1:0] STEP_LOW    = 2'd0;
    localparam logic [1:0] STEP_CROSS1 = 2'd1;
    localparam logic [1:0] STEP_CROSS2 = 2'd2;
    localparam logic [1:0] STEP_SUM    = 2'd3;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    t_word       r_a;
    t_word       r_b;
    t_word       r_pp;
    logic [31:0] r_c1;
    logic [31:0] r_c2;
    t_word       r_p;

    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] prod;

    always_comb begin
        unique case (r_step)
            STEP_LOW: begin
                op_x = r_a[31:0];
                op_y = r_b[31:0];
            end
            STEP_CROSS1: begin
                op_x = r_a[31:0];
                op_y = r_b[63:32];
            end
            default: begin
                op_x = r_a[63:32];
                op_y = r_b[31:0];
            end
        endcase
    end

    assign prod = op_x * op_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_LOW;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_LOW;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == STEP_SUM) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            unique case (r_step)
                STEP_LOW:    r_pp <= prod;
                STEP_CROSS1: r_c1 <= prod[31:0];
                STEP_CROSS2: r_c2 <= prod[31:0];
                STEP_SUM:    r_p  <= {r_pp[63:32] + r_c1 + r_c2, r_pp[31:0]};
                default:     r_p  <= r_p;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

// ===== rtl/mm3_front.sv =====
// Front end: accepts blocks, masks tails, tracks message start and byte total.
`timescale 1ns / 1ps

module mm3_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mm3_in_if.sink        i_req,
    input  logic          i_full,
    output logic          o_push,
    output mm3_pkg::t_job o_job
);
    import mm3_pkg::*;

    logic        r_in_msg;
    logic [31:0] r_total;

    logic [4:0]  cnt;
    logic [4:0]  add_n;
    logic [4:0]  hi_cnt;
    logic [3:0]  lo_bytes;
    logic [3:0]  hi_bytes;
    logic        full;
    logic [31:0] base;
    logic [32:0] sum;
    logic [31:0] total;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        cnt      = (i_req.byte_count > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : i_req.byte_count;
        // Non-final blocks always count as full, whatever the byte count says.
        full     = !i_req.last || (cnt == 5'(BLOCK_BYTES));
        add_n    = i_req.last ? cnt : 5'(BLOCK_BYTES);
        hi_cnt   = cnt - 5'(HALF_BYTES);
        lo_bytes = (cnt >= 5'(HALF_BYTES)) ? 4'(HALF_BYTES) : cnt[3:0];
        hi_bytes = (cnt > 5'(HALF_BYTES)) ? hi_cnt[3:0] : 4'd0;
        base     = r_in_msg ? r_total : 32'd0;
        sum      = {1'b0, base} + {28'd0, add_n};
        total    = sum[32] ? '1 : sum[31:0];

        o_job.k1    = full ? i_req.block_low  : (i_req.block_low  & byte_mask(lo_bytes));
        o_job.k2    = full ? i_req.block_high : (i_req.block_high & byte_mask(hi_bytes));
        o_job.full  = full;
        o_job.last  = i_req.last;
        o_job.start = !r_in_msg;
        o_job.len   = total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_total  <= '0;
        end else if (o_push) begin
            r_in_msg <= !i_req.last;
            r_total  <= total;
        end
    end

endmodule

// ===== rtl/mm3_queue.sv =====
// Short request queue between the front end and the mixing core.
`timescale 1ns / 1ps

module mm3_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mm3_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output mm3_pkg::t_job o_job
);
    import mm3_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (do_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== rtl/mm3_core.sv =====
// Back end: lane mixing, length fold and finalizer over a shared multiplier.
`timescale 1ns / 1ps

module mm3_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_seed_we,
    input  logic [31:0]   i_seed_wdata,
    input  logic          i_job_valid,
    input  mm3_pkg::t_job i_job,
    output logic          o_job_pop,
    mm3_out_if.source     o_rsp
);
    import mm3_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_MUL   = 11'b000_0000_0010,
        ST_MIX1  = 11'b000_0000_0100,
        ST_MIX2  = 11'b000_0000_1000,
        ST_MIX3  = 11'b000_0001_0000,
        ST_MIX4  = 11'b000_0010_0000,
        ST_FOLD1 = 11'b000_0100_0000,
        ST_FOLD2 = 11'b000_1000_0000,
        ST_SUM1  = 11'b001_0000_0000,
        ST_SUM2  = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } t_state;

    // Product sequence: two per key scramble, two per lane finalizer.
    typedef enum logic [2:0] {
        OP_K1_A = 3'd0,
        OP_K1_B = 3'd1,
        OP_K2_A = 3'd2,
        OP_K2_B = 3'd3,
        OP_F1_A = 3'd4,
        OP_F1_B = 3'd5,
        OP_F2_A = 3'd6,
        OP_F2_B = 3'd7
    } t_mul_op;

    t_state      r_state, n_state;
    t_mul_op     r_op, n_op;
    logic        r_start, n_start;
    t_word       r_h1, n_h1;
    t_word       r_h2, n_h2;
    t_word       r_s1, n_s1;
    t_word       r_s2, n_s2;
    t_job        r_job, n_job;
    logic [31:0] r_seed;
    logic        r_out_valid, n_out_valid;
    t_word       r_out_low, n_out_low;
    t_word       r_out_high, n_out_high;
    logic        r_out_long, n_out_long;

    t_word mul_a;
    t_word mul_b;
    logic  mul_done;
    t_word mul_p;
    t_word len64;

    mm3_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    assign len64 = {32'd0, r_job.len};

    always_comb begin
        unique case (r_op)
            OP_K1_A: begin
                mul_a = r_job.k1;
                mul_b = MUL_C1;
            end
            OP_K1_B: begin
                mul_a = rotl64(mul_p, 31);
                mul_b = MUL_C2;
            end
            OP_K2_A: begin
                mul_a = r_job.k2;
                mul_b = MUL_C2;
            end
            OP_K2_B: begin
                mul_a = rotl64(mul_p, 33);
                mul_b = MUL_C1;
            end
            OP_F1_A: begin
                mul_a = fmix_shift(r_h1);
                mul_b = FMIX_M1;
            end
            OP_F1_B: begin
                mul_a = fmix_shift(mul_p);
                mul_b = FMIX_M2;
            end
            OP_F2_A: begin
                mul_a = fmix_shift(r_h2);
                mul_b = FMIX_M1;
            end
            OP_F2_B: begin
                mul_a = fmix_shift(mul_p);
                mul_b = FMIX_M2;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_start     = 1'b0;
        n_h1        = r_h1;
        n_h2        = r_h2;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_job       = r_job;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_low   = r_out_low;
        n_out_high  = r_out_high;
        n_out_long  = r_out_long;
        o_job_pop   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    if (i_job.start) begin
                        n_h1 = {32'd0, r_seed};
                        n_h2 = {32'd0, r_seed};
                    end
                    n_op    = OP_K1_A;
                    n_start = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    case (r_op)
                        OP_K1_B: n_s1 = mul_p;
                        OP_K2_B: n_s2 = mul_p;
                        OP_F1_B: n_h1 = fmix_shift(mul_p);
                        OP_F2_B: n_h2 = fmix_shift(mul_p);
                        default: n_s1 = r_s1;
                    endcase
                    if (r_op == OP_K2_B) begin
                        n_state = ST_MIX1;
                    end else if (r_op == OP_F2_B) begin
                        n_state = ST_SUM1;
                    end else begin
                        n_op    = t_mul_op'(r_op + 3'd1);
                        n_start = 1'b1;
                    end
                end
            end
            ST_MIX1: begin
                if (r_job.full) begin
                    n_h1    = rotl64(r_h1 ^ r_s1, 27) + r_h2;
                    n_state = ST_MIX2;
                end else begin
                    // Tail: zero-masked keys scramble to zero, so xor both lanes.
                    n_h1    = r_h1 ^ r_s1;
                    n_h2    = r_h2 ^ r_s2;
                    n_state = ST_FOLD1;
                end
            end
            ST_MIX2: begin
                n_h1    = (r_h1 << 2) + r_h1 + ADD_H1;
                n_state = ST_MIX3;
            end
            ST_MIX3: begin
                n_h2    = rotl64(r_h2 ^ r_s2, 31) + r_h1;
                n_state = ST_MIX4;
            end
            ST_MIX4: begin
                n_h2    = (r_h2 << 2) + r_h2 + ADD_H2;
                n_state = r_job.last ? ST_FOLD1 : ST_IDLE;
            end
            ST_FOLD1: begin
                n_h1    = (r_h1 ^ len64) + (r_h2 ^ len64);
                n_h2    = r_h2 ^ len64;
                n_state = ST_FOLD2;
            end
            ST_FOLD2: begin
                n_h2    = r_h2 + r_h1;
                n_op    = OP_F1_A;
                n_start = 1'b1;
                n_state = ST_MUL;
            end
            ST_SUM1: begin
                n_h1    = r_h1 + r_h2;
                n_state = ST_SUM2;
            end
            ST_SUM2: begin
                n_h2    = r_h2 + r_h1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output register is free.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_low   = r_h1;
                    n_out_high  = r_h2;
                    n_out_long  = r_job.len[31];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_seed      <= '0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            if (i_seed_we) begin
                r_seed <= i_seed_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_h1       <= n_h1;
        r_h2       <= n_h2;
        r_s1       <= n_s1;
        r_s2       <= n_s2;
        r_job      <= n_job;
        r_out_low  <= n_out_low;
        r_out_high <= n_out_high;
        r_out_long <= n_out_long;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.hash_low  = r_out_low;
    assign o_rsp.hash_high = r_out_high;
    assign o_rsp.too_long  = r_out_long;

endmodule

// ===== rtl/mm3_checker.sv =====
// Port-level checks for the hash block, bound to the top level.
`timescale 1ns / 1ps

module mm3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_req_last,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [63:0] i_rsp_hash_low,
    input logic [63:0] i_rsp_hash_high,
    input logic        i_rsp_too_long
);
    import mm3_pkg::*;

    logic [2:0] r_pending;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    // Count final requests whose digest has not been taken yet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if ((req_acc && i_req_last) && !rsp_acc) begin
            r_pending <= r_pending + 3'd1;
        end else if (!(req_acc && i_req_last) && rsp_acc) begin
            r_pending <= r_pending - 3'd1;
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_hash_low)
            && $stable(i_rsp_hash_high) && $stable(i_rsp_too_long))
        else $error("digest changed while stalled");

    a_rsp_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_pending != 3'd0)
        else $error("digest without an outstanding final request");

    a_no_instant_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && r_pending == 3'd0 |=> !i_rsp_valid)
        else $error("digest appeared one cycle after request");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'(QUEUE_DEPTH + 2))
        else $error("more final requests in flight than storage allows");

endmodule

bind murmur3_x64_128_hash_top mm3_checker u_mm3_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_req_last      (i_req.last),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_hash_low  (o_rsp.hash_low),
    .i_rsp_hash_high (o_rsp.hash_high),
    .i_rsp_too_long  (o_rsp.too_long)
);

// ===== tb/mm3_digest_checker.sv =====
// Checker for the MurmurHash3 block: predicts each digest from the observed requests and compares.
`timescale 1ns / 1ps

module mm3_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_wdata,
    mm3_in_if           i_req,
    mm3_out_if          i_rsp,
    output int          o_errors,
    output int          o_pending
);
    import mm3_pkg::*;

    typedef struct packed {
        t_word h1;
        t_word h2;
        logic  over;
    } t_digest;

    logic [31:0] seed_q;
    t_word       lane_a;
    t_word       lane_b;
    logic [31:0] msg_bytes;
    logic        mid_msg;
    t_digest     digest_q[$];
    int          err_cnt;
    t_digest     got;
    t_digest     want;

    function automatic t_word rot_left(t_word x, int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_word mix_k1(t_word k);
        k = k * MUL_C1;
        k = rot_left(k, 31);
        return k * MUL_C2;
    endfunction

    function automatic t_word mix_k2(t_word k);
        k = k * MUL_C2;
        k = rot_left(k, 33);
        return k * MUL_C1;
    endfunction

    function automatic t_word avalanche(t_word k);
        k = k ^ (k >> 33);
        k = k * FMIX_M1;
        k = k ^ (k >> 33);
        k = k * FMIX_M2;
        return k ^ (k >> 33);
    endfunction

    // Keep the lowest n bytes of a word.
    function automatic t_word keep_bytes(t_word w, int unsigned n);
        if (n >= 8)
            return w;
        return w & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic void body_round(t_word lo, t_word hi);
        lane_a = lane_a ^ mix_k1(lo);
        lane_a = rot_left(lane_a, 27);
        lane_a = lane_a + lane_b;
        lane_a = lane_a * 64'd5 + ADD_H1;
        lane_b = lane_b ^ mix_k2(hi);
        lane_b = rot_left(lane_b, 31);
        lane_b = lane_b + lane_a;
        lane_b = lane_b * 64'd5 + ADD_H2;
    endfunction

    // Saturate the running length at all ones.
    function automatic void add_len(int unsigned n);
        logic [32:0] sum;
        sum = {1'b0, msg_bytes} + 33'(n);
        msg_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic void absorb_block(t_word lo, t_word hi, logic [4:0] cnt, logic fin);
        int unsigned n;
        t_digest     d;
        if (!mid_msg) begin
            lane_a = {32'd0, seed_q};
            lane_b = {32'd0, seed_q};
            msg_bytes = '0;
        end
        if (!fin) begin
            // A non-final request always counts as a full block.
            body_round(lo, hi);
            add_len(BLOCK_BYTES);
            mid_msg = 1'b1;
        end else begin
            n = (cnt > 5'd16) ? BLOCK_BYTES : cnt;
            if (n == BLOCK_BYTES) begin
                body_round(lo, hi);
            end else if (n > 0) begin
                if (n > HALF_BYTES)
                    lane_b = lane_b ^ mix_k2(keep_bytes(hi, n - HALF_BYTES));
                lane_a = lane_a ^ mix_k1(keep_bytes(lo, n));
            end
            add_len(n);
            lane_a = lane_a ^ {32'd0, msg_bytes};
            lane_b = lane_b ^ {32'd0, msg_bytes};
            lane_a = lane_a + lane_b;
            lane_b = lane_b + lane_a;
            lane_a = avalanche(lane_a);
            lane_b = avalanche(lane_b);
            lane_a = lane_a + lane_b;
            lane_b = lane_b + lane_a;
            d.h1 = lane_a;
            d.h2 = lane_b;
            d.over = (msg_bytes > 32'h7FFF_FFFF);
            digest_q.push_back(d);
            mid_msg = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_q = '0;
            lane_a = '0;
            lane_b = '0;
            msg_bytes = '0;
            mid_msg = 1'b0;
            digest_q.delete();
            err_cnt = 0;
        end else begin
            if (i_seed_we)
                seed_q = i_seed_wdata;
            if (i_req.valid && i_req.ready)
                absorb_block(i_req.block_low, i_req.block_high, i_req.byte_count, i_req.last);
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.hash_low, i_rsp.hash_high, i_rsp.too_long};
                if (digest_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: digest with no message pending: h1=%h h2=%h long=%b",
                                 $realtime, got.h1, got.h2, got.over);
                end else begin
                    want = digest_q.pop_front();
                    if (got.h1 !== want.h1 || got.h2 !== want.h2 || got.over !== want.over) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("%0t: digest mismatch", $realtime);
                            $display("  h1   exp %h got %h", want.h1, got.h1);
                            $display("  h2   exp %h got %h", want.h2, got.h2);
                            $display("  long exp %b got %b", want.over, got.over);
                        end
                    end
                end
            end
        end
        o_errors <= err_cnt;
        o_pending <= digest_q.size();
    end

endmodule

// ===== tb/tb_murmur3_x64_128_hash_top.sv =====
// Testbench top for the MurmurHash3 x64 128-bit hash block: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module tb_murmur3_x64_128_hash_top;
    import mm3_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int ITEMS_PER_PHASE = 130;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_seed_we;
    logic [31:0] i_seed_wdata;
    int          fail_cnt;
    int          open_digests;
    int          idle_cycles = 0;
    bit          gaps_on = 1'b1;
    logic [31:0] seeds [5];

    mm3_in_if  req_if ();
    mm3_out_if rsp_if ();

    murmur3_x64_128_hash_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_wdata (i_seed_wdata),
        .i_req        (req_if),
        .o_rsp        (rsp_if)
    );

    mm3_digest_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_wdata (i_seed_wdata),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_errors     (fail_cnt),
        .o_pending    (open_digests)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        if (r < 98)
            return $urandom_range(5, 30);
        return $urandom_range(60, 150);
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Result side: hold ready for a while, then drop it for a random gap.
    initial begin
        int unsigned n;
        forever begin
            rsp_if.ready <= 1'b1;
            repeat (gaps_on ? $urandom_range(1, 12) : 1) @(posedge i_clk);
            n = gaps_on ? gap_len() : 0;
            if (n > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_block(t_word lo, t_word hi, logic [4:0] cnt, logic fin);
        int unsigned gap;
        gap = gaps_on ? gap_len() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.block_low <= lo;
        req_if.block_high <= hi;
        req_if.byte_count <= cnt;
        req_if.last <= fin;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Wait out every pending digest, then let the core go quiet.
    task automatic settle();
        do @(posedge i_clk); while (open_digests != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(logic [31:0] v);
        i_seed_we <= 1'b1;
        i_seed_wdata <= v;
        @(posedge i_clk);
        i_seed_we <= 1'b0;
    endtask

    task automatic run_directed();
        // Empty messages and a single full block.
        send_block('0, '0, 5'd0, 1'b1);
        send_block('1, '1, 5'd0, 1'b1);
        send_block('1, '1, 5'd16, 1'b1);
        // Partial tails around the lane boundary; unused bytes must be masked.
        send_block('1, '1, 5'd1, 1'b1);
        send_block('1, '1, 5'd7, 1'b1);
        send_block('1, '1, 5'd8, 1'b1);
        send_block('1, '1, 5'd9, 1'b1);
        send_block('1, '1, 5'd15, 1'b1);
        // Counts above sixteen on the final request act as a full block.
        send_block(rand_word(), rand_word(), 5'd17, 1'b1);
        send_block(rand_word(), rand_word(), 5'd31, 1'b1);
        // Non-final requests mix a full block whatever their byte count.
        send_block('1, '1, 5'd0, 1'b0);
        send_block('0, '0, 5'd31, 1'b0);
        send_block('1, '0, 5'd16, 1'b0);
        send_block(rand_word(), rand_word(), 5'd5, 1'b1);
        send_block('0, '0, 5'd16, 1'b0);
        send_block('1, '1, 5'd16, 1'b1);
        req_if.valid <= 1'b0;
    endtask

    task automatic random_phase(int unsigned quota);
        int unsigned sent;
        int unsigned blocks;
        logic [4:0]  cnt;
        sent = 0;
        while (sent < quota) begin
            blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
            for (int unsigned b = 1; b < blocks; b++) begin
                cnt = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
                send_block(rand_word(), rand_word(), cnt, 1'b0);
            end
            case ($urandom_range(0, 9))
                0: cnt = 5'd0;
                1: cnt = 5'($urandom_range(17, 31));
                2, 3: cnt = 5'd16;
                default: cnt = 5'($urandom_range(1, 15));
            endcase
            send_block(rand_word(), rand_word(), cnt, 1'b1);
            sent += blocks;
        end
        req_if.valid <= 1'b0;
    endtask

    initial begin
        req_if.valid <= 1'b0;
        req_if.block_low <= '0;
        req_if.block_high <= '0;
        req_if.byte_count <= '0;
        req_if.last <= 1'b0;
        i_seed_we <= 1'b0;
        i_seed_wdata <= '0;
        i_rst_n <= 1'b0;
        seeds = '{32'hFFFF_FFFF, $urandom(), 32'h8000_0000, $urandom(), 32'h0000_0000};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        settle();

        foreach (seeds[p]) begin
            write_seed(seeds[p]);
            // One phase runs with no idling on either side.
            gaps_on = (p != 2);
            random_phase(ITEMS_PER_PHASE);
            settle();
        end

        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
